// File: rtl/lbp3x3_pkg.sv
// lbp3x3_pkg: shared constants and types of the 3x3 local binary pattern stream unit
// no dependencies; imported by every lbp3x3 module except lbp3x3_ram, and by the top level
`default_nettype none

package lbp3x3_pkg;

   // image geometry limits
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 12;
   localparam int PIX_W     = 8;
   localparam int CODE_W    = 8;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd3;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd3;

   // queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 2);

   // one classified pixel with its column neighbours from the line buffers
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic             emit;
      logic             last;
   } lbp3x3_entry_type;

endpackage

`default_nettype wire

// File: rtl/lbp3x3_ram.sv
// lbp3x3_ram: generic single-write, single-read RAM with registered read data
// no dependencies; read returns the old contents on a same-address write
`default_nettype none

module lbp3x3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/lbp3x3_front.sv
// lbp3x3_front: configuration registers, raster position counters and line buffers
// depends on lbp3x3_pkg and lbp3x3_ram; pushes one entry per kept pixel into the queue
`default_nettype none

module lbp3x3_front
   import lbp3x3_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration writes
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   // pixel request
   input  wire logic                  req_valid,
   input  wire logic [PIX_W-1:0]      req_pixel,
   output logic                       req_ready,
   // queue side
   input  wire logic [QLVL_W-1:0]     q_level,
   output logic                       q_push,
   output lbp3x3_entry_type           q_entry
);

   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]    s1_pixel_ff;
   logic [COL_W-1:0]    s1_idx_ff;
   logic                s1_emit_ff;
   logic                s1_last_ff;

   logic [WIDTH_W-1:0]  w_eff;
   logic                active;
   logic                accept;
   logic                wrap_col;
   logic [WIDTH_W-1:0]  col_cur;
   logic [HEIGHT_W:0]   row_adv;
   logic [HEIGHT_W-1:0] row_cur;
   logic [WIDTH_W-1:0]  col_next;
   logic                col_end;
   logic [HEIGHT_W:0]   row_inc;
   logic                emit;
   logic                last;
   logic [QLVL_W-1:0]   in_flight;
   logic [PIX_W-1:0]    rd_above;
   logic [PIX_W-1:0]    rd_two_above;

   // configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_data[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry
   assign w_eff  = (width_ff > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_ff;
   assign active = (w_eff >= WIDTH_W'(3)) && (height_ff >= HEIGHT_W'(3));

   // room for the pixel in stage one plus the new one
   assign in_flight = q_level + QLVL_W'(s1_valid_ff);
   assign req_ready = in_flight < QLVL_W'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   // position of this pixel, folding counters left out of range by a register write
   always_comb begin
      wrap_col = {1'b0, col_ff} >= w_eff;
      col_cur  = wrap_col ? '0 : {1'b0, col_ff};
      row_adv  = {1'b0, row_ff} + (HEIGHT_W+1)'(wrap_col);
      row_cur  = (row_adv >= {1'b0, height_ff}) ? '0 : row_adv[HEIGHT_W-1:0];
      emit     = (row_cur >= HEIGHT_W'(2)) && (col_cur >= WIDTH_W'(2));
      last     = (row_cur == height_ff - HEIGHT_W'(1)) && (col_cur == w_eff - WIDTH_W'(1));
      col_next = col_cur + WIDTH_W'(1);
      col_end  = col_next >= w_eff;
      row_inc  = {1'b0, row_cur} + (HEIGHT_W+1)'(1);
   end

   // next counter values
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept && active) begin
         if (col_end) begin
            col_in = '0;
            row_in = (row_inc >= {1'b0, height_ff}) ? '0 : row_inc[HEIGHT_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
            row_in = row_cur;
         end
      end
   end

   assign s1_valid_in = accept && active;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_pixel_ff <= req_pixel;
         s1_idx_ff   <= col_cur[COL_W-1:0];
         s1_emit_ff  <= emit;
         s1_last_ff  <= last;
      end
   end

   // line buffers: read at accept, shift the column down in the following cycle
   lbp3x3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_above (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (s1_valid_in),
      .rd_addr (col_cur[COL_W-1:0]),
      .rd_data (rd_above)
   );

   lbp3x3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_two_above (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (rd_above),
      .rd_en   (s1_valid_in),
      .rd_addr (col_cur[COL_W-1:0]),
      .rd_data (rd_two_above)
   );

   // queue entry
   assign q_push        = s1_valid_ff;
   assign q_entry.pixel = s1_pixel_ff;
   assign q_entry.top   = rd_two_above;
   assign q_entry.mid   = rd_above;
   assign q_entry.emit  = s1_emit_ff;
   assign q_entry.last  = s1_last_ff;

endmodule

`default_nettype wire

// File: rtl/lbp3x3_queue.sv
// lbp3x3_queue: short first-in first-out queue of classified pixels
// depends on lbp3x3_pkg; the front never pushes into a full queue
`default_nettype none

module lbp3x3_queue
   import lbp3x3_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lbp3x3_entry_type  push_entry,
   input  wire logic              pop,
   output logic                   head_valid,
   output lbp3x3_entry_type       head_entry,
   output logic [QLVL_W-1:0]      level
);

   lbp3x3_entry_type  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign level      = count_ff;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QLVL_W'(push) - QLVL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lbp3x3_back.sv
// lbp3x3_back: 3x3 window registers, pattern compare and result register
// depends on lbp3x3_pkg; takes one queue entry per cycle while the result side flows
`default_nettype none

module lbp3x3_back
   import lbp3x3_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire lbp3x3_entry_type  head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [CODE_W-1:0]      rsp_code,
   output logic                   rsp_last,
   input  wire logic              rsp_ready
);

   // [0] top col-2, [1] top col-1, [2] mid col-2, [3] mid col-1,
   // [4] bottom col-2, [5] bottom col-1
   logic [PIX_W-1:0]  win_ff [6];
   logic [PIX_W-1:0]  win_in [6];
   logic              out_valid_ff, out_valid_in;
   logic [CODE_W-1:0] out_code_ff;
   logic              out_last_ff;
   logic [PIX_W-1:0]  center;
   logic [CODE_W-1:0] code;

   assign pop = head_valid && (!out_valid_ff || rsp_ready);

   // neighbour compares against the centre
   always_comb begin
      center  = win_ff[3];
      code[7] = win_ff[0]        >= center;
      code[6] = win_ff[1]        >= center;
      code[5] = head_entry.top   >= center;
      code[4] = head_entry.mid   >= center;
      code[3] = head_entry.pixel >= center;
      code[2] = win_ff[5]        >= center;
      code[1] = win_ff[4]        >= center;
      code[0] = win_ff[2]        >= center;
   end

   // window shift
   always_comb begin
      win_in = win_ff;
      if (pop) begin
         win_in[0] = win_ff[1];
         win_in[1] = head_entry.top;
         win_in[2] = win_ff[3];
         win_in[3] = head_entry.mid;
         win_in[4] = win_ff[5];
         win_in[5] = head_entry.pixel;
      end
   end

   // result register valid
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (pop) begin
         out_valid_in = head_entry.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '{default: '0};
         out_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop && head_entry.emit) begin
         out_code_ff <= code;
         out_last_ff <= head_entry.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_code  = out_code_ff;
   assign rsp_last  = out_last_ff;

endmodule

`default_nettype wire

// File: rtl/lbp3x3_stream_unit.sv
// lbp_3x3_stream_unit: top level of the 3x3 local binary pattern stream unit
// depends on lbp3x3_pkg, lbp3x3_front, lbp3x3_queue and lbp3x3_back
//
// Pixels enter in raster order, one per cycle while the queue has room; each pixel at
// row >= 2 and column >= 2 yields the 8-bit pattern of the window centred one row up and
// one column back, and the last code of a frame carries tlast. The code of a request
// passes through stage one with the line-buffer read, then a queue slot, then the result
// register before it is presented on the result side; each line buffer is read once per
// accepted pixel, which keeps the rate at one pixel per cycle. A four-entry queue sits
// between the classifying front and the compare back, so the request side keeps flowing
// while the result side stalls, until the queue fills. Width and height are written
// through the csr channel (index 0 width, index 1 height); the user must write them only
// while no request is in flight, which the unit itself does not enforce. A width or height
// below 3 makes the unit swallow pixels without a result.
`default_nettype none

module lbp_3x3_stream_unit
   import lbp3x3_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] pixel
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] lbp_code
   output logic                       rsp_tlast,
   // configuration writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic              q_push;
   lbp3x3_entry_type  q_push_entry;
   logic              q_pop;
   logic              q_head_valid;
   lbp3x3_entry_type  q_head_entry;
   logic [QLVL_W-1:0] q_level;

   assign csr_ready = 1'b1;

   // classify and buffer lines
   lbp3x3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_tvalid),
      .req_pixel (req_tdata),
      .req_ready (req_tready),
      .q_level   (q_level),
      .q_push    (q_push),
      .q_entry   (q_push_entry)
   );

   // decoupling queue
   lbp3x3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .level      (q_level)
   );

   // window and pattern
   lbp3x3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_code   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_ready  (rsp_tready)
   );

endmodule

`default_nettype wire

// File: dv/lbp_3x3_stream_unit_test.sv
`timescale 1ns / 100ps
// lbp_3x3_stream_unit_test: self-checking bench for the 3x3 local binary pattern stream unit
// needs lbp3x3_pkg and lbp_3x3_stream_unit; a built-in pattern predictor checks every code

module lbp_3x3_stream_unit_test;
   import lbp3x3_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RAND_PIXELS   = 250;
   localparam int QUIET_PIXELS  = 80;
   localparam int TABLE_ROWS    = 25;
   localparam int SHOWN_ERRORS  = 10;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              last;
   } lbp_result_type;

   typedef enum logic [1:0] {
      ROW_PIXEL,
      ROW_WIDTH,
      ROW_HEIGHT
   } stim_kind_type;

   typedef struct packed {
      stim_kind_type         kind;
      logic [CSR_DATA_W-1:0] value;
      logic                  typed;
      logic [CODE_W-1:0]     code;
      logic                  last;
   } stim_row_type;

   // dut ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata = '0;   // [7:0] pixel
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [CODE_W-1:0]     rsp_tdata;        // [7:0] lbp_code
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state
   bit [PIX_W-1:0]    line_one_up [0:MAX_WIDTH-1];
   bit [PIX_W-1:0]    line_two_up [0:MAX_WIDTH-1];
   bit [1:0]          rows_seen [0:MAX_WIDTH-1];
   bit [PIX_W-1:0]    win_px [0:5];
   int                col_cnt = 0;
   int                row_cnt = 0;
   logic [WIDTH_W-1:0]  cfg_width = WIDTH_RESET;
   logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RESET;
   logic [WIDTH_W-1:0]  last_good_width = WIDTH_RESET;

   lbp_result_type pending_codes [$];
   int          error_count = 0;
   int unsigned cycle_count = 0;
   bit          tx_idle_en = 1'b0;
   bit          rx_idle_en = 1'b0;
   bit          quiet = 1'b0;
   int          rx_stall_left = 0;

   // directed stimulus: centre-peak frame, bit-order frame, then degenerate geometry
   stim_row_type directed_rows [0:TABLE_ROWS-1] = '{
      '{ROW_PIXEL, 12'd0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd255, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd0, 1'b1, 8'h00, 1'b1},
      '{ROW_PIXEL, 12'd10, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd20, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd30, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd40, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd25, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd5, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd50, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd1, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd25, 1'b0, 8'h00, 1'b0},
      '{ROW_WIDTH, 12'd2, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd7, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd200, 1'b0, 8'h00, 1'b0},
      '{ROW_WIDTH, 12'd3, 1'b0, 8'h00, 1'b0},
      '{ROW_HEIGHT, 12'd0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, 12'd99, 1'b0, 8'h00, 1'b0},
      '{ROW_HEIGHT, 12'd3, 1'b0, 8'h00, 1'b0}
   };

   lbp_3x3_stream_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[lbp_3x3_stream_unit] ERROR");
         $finish;
      end
   end

   function automatic int effective_width(input logic [WIDTH_W-1:0] w);
      return (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
   endfunction

   function automatic bit geometry_live();
      return effective_width(cfg_width) >= 3 && cfg_height >= 3;
   endfunction

   // leading columns whose two line-buffer entries have both been written
   function automatic int filled_cols();
      int k;
      k = 0;
      while (k < MAX_WIDTH && rows_seen[k] == 2'd2)
         k++;
      return k;
   endfunction

   // a width change must never make a code depend on a line-buffer entry never written
   function automatic bit width_safe(input logic [WIDTH_W-1:0] w);
      int new_w;
      int cur_w;
      new_w = effective_width(w);
      cur_w = effective_width(cfg_width);
      return new_w < 3 || (col_cnt == 0 && row_cnt == 0) ||
             (cur_w >= 3 && new_w <= cur_w) || new_w <= filled_cols();
   endfunction

   // pattern of the window centred one row up and one column back
   task automatic lbp_predict(input logic [PIX_W-1:0] px, output bit emits,
                              output lbp_result_type res);
      int eff_w;
      int c;
      int r;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] ctr;
      emits = 1'b0;
      res = '0;
      if (geometry_live()) begin
         eff_w = effective_width(cfg_width);
         c = col_cnt;
         r = row_cnt;
         // counters left out of range by a register write
         if (c >= eff_w) begin
            c = 0;
            r++;
         end
         if (r >= cfg_height)
            r = 0;
         top = line_two_up[c];
         mid = line_one_up[c];
         ctr = win_px[3];
         if (r >= 2 && c >= 2) begin
            emits = 1'b1;
            res.code = {win_px[0] >= ctr, win_px[1] >= ctr, top >= ctr, mid >= ctr,
                        px >= ctr, win_px[5] >= ctr, win_px[4] >= ctr, win_px[2] >= ctr};
            res.last = (r == cfg_height - 1) && (c == eff_w - 1);
         end
         win_px[0] = win_px[1];
         win_px[1] = top;
         win_px[2] = win_px[3];
         win_px[3] = mid;
         win_px[4] = win_px[5];
         win_px[5] = px;
         line_two_up[c] = mid;
         line_one_up[c] = px;
         if (rows_seen[c] != 2'd2)
            rows_seen[c] = rows_seen[c] + 2'd1;
         c++;
         if (c >= eff_w) begin
            c = 0;
            r++;
            if (r >= cfg_height)
               r = 0;
         end
         col_cnt = c;
         row_cnt = r;
      end
   endtask

   // one pixel request, with an optional idle burst ahead of it
   task automatic send_pixel(input logic [PIX_W-1:0] px, input bit use_typed,
                             input lbp_result_type typed_res);
      bit emits;
      lbp_result_type res;
      if (tx_idle_en && !quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      lbp_predict(px, emits, res);
      if (use_typed)
         pending_codes.push_back(typed_res);
      else if (emits)
         pending_codes.push_back(res);
   endtask

   // register write once the unit has drained
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) begin
         cfg_width = value[WIDTH_W-1:0];
         if (effective_width(cfg_width) >= 3)
            last_good_width = cfg_width;
      end else begin
         cfg_height = value[HEIGHT_W-1:0];
      end
   endtask

   task automatic send_random(input int count, input int base, input int span);
      for (int i = 0; i < count; i++)
         send_pixel(PIX_W'(base + $urandom_range(0, span)), 1'b0, '0);
   endtask

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= SHOWN_ERRORS)
         $display("[%0t] %s", $time, msg);
   endfunction

   // result side: random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_stall_left != 0) begin
         rx_stall_left = rx_stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rx_idle_en && !quiet && $urandom_range(0, 9) == 0) begin
         rx_stall_left = $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each accepted code with the oldest expectation
   always @(posedge clock) begin : code_check
      lbp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_codes.size() == 0) begin
            note_error($sformatf("unexpected code %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            want = pending_codes.pop_front();
            if (rsp_tdata !== want.code || rsp_tlast !== want.last)
               note_error($sformatf("code mismatch: expected %02h last %0b, got %02h last %0b",
                                    want.code, want.last, rsp_tdata, rsp_tlast));
         end
      end
   end

   initial begin : stimulus
      int rand_sent;
      int n;
      int base;
      int span;
      logic [WIDTH_W-1:0] w;
      lbp_result_type typed_res;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < TABLE_ROWS; i++) begin
         case (directed_rows[i].kind)
            ROW_WIDTH: begin
               write_reg(CSR_IMAGE_WIDTH, directed_rows[i].value);
            end
            ROW_HEIGHT: begin
               write_reg(CSR_IMAGE_HEIGHT, directed_rows[i].value);
            end
            default: begin
               typed_res.code = directed_rows[i].code;
               typed_res.last = directed_rows[i].last;
               send_pixel(directed_rows[i].value[PIX_W-1:0], directed_rows[i].typed, typed_res);
            end
         endcase
      end

      // oversized width saturates: a full row wraps at the buffer depth
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      write_reg(CSR_IMAGE_WIDTH, 12'hFFF);
      send_random(MAX_WIDTH + 2, 0, 255);
      // narrower width in mid-frame keeps the column, then the frame completes
      write_reg(CSR_IMAGE_WIDTH, 12'd5);
      send_random(8, 0, 255);
      // tallest frame, then a height cut that forces the row counter to wrap
      write_reg(CSR_IMAGE_HEIGHT, 12'hFFF);
      send_random(20, 100, 3);
      write_reg(CSR_IMAGE_HEIGHT, 12'd3);

      // random phases of geometry and content
      rand_sent = 0;
      while (rand_sent < RAND_PIXELS) begin
         tx_idle_en = $urandom_range(0, 3) != 0;
         rx_idle_en = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 15))
               0:       w = WIDTH_W'($urandom_range(0, 2));
               1:       w = $urandom_range(0, 1) ? 11'd2047 : 11'd1024;
               2:       w = WIDTH_W'($urandom_range(13, 2047));
               default: w = WIDTH_W'($urandom_range(3, 12));
            endcase
            if (!width_safe(w))
               w = last_good_width;
            write_reg(CSR_IMAGE_WIDTH, {1'($urandom_range(0, 1)), w});
         end
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 15))
               0:       write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(0, 2)));
               1:       write_reg(CSR_IMAGE_HEIGHT, 12'hFFF);
               2:       write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(9, 4095)));
               default: write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(3, 8)));
            endcase
         end
         // narrow spans give many equal neighbours
         base = int'($urandom_range(0, 255));
         case ($urandom_range(0, 3))
            0:       span = 0;
            1:       span = 2;
            default: span = 255;
         endcase
         n = geometry_live() ? int'($urandom_range(1, 90)) : int'($urandom_range(1, 4));
         if (geometry_live())
            rand_sent += n;
         send_random(n, base, span);
         quiet = rand_sent >= RAND_PIXELS - QUIET_PIXELS;
      end

      // drain and let the pipeline settle
      req_tvalid <= 1'b0;
      quiet = 1'b1;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_codes.size() == 0)
         $display("[lbp_3x3_stream_unit] OK");
      else
         $display("[lbp_3x3_stream_unit] ERROR");
      $finish;
   end

endmodule

// File: lbp_3x3_stream_unit.f
rtl/lbp3x3_pkg.sv
rtl/lbp3x3_ram.sv
rtl/lbp3x3_front.sv
rtl/lbp3x3_queue.sv
rtl/lbp3x3_back.sv
rtl/lbp3x3_stream_unit.sv
dv/lbp_3x3_stream_unit_test.sv
